[rtl/lss_pkg.sv]
// Shared constants and types of the Laplacian stencil sum unit.
// No dependencies; the two channel interfaces and the unit import this package.
package lss_pkg;

  // Field and register widths
  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 56;
  localparam int DENS_W   = 16;
  localparam int GS_W     = 9;
  localparam int CFG_W    = 16;

  // Grid geometry
  localparam int MAX_GRID = 256;
  localparam int MIN_GRID = 3;
  localparam int COL_W    = $clog2(MAX_GRID);
  localparam int N_W      = COL_W + 1;

  // Stencil arithmetic: four neighbors minus four times the center
  localparam int LAP_W  = SAMPLE_W + 3;
  localparam int PROD_W = DENS_W + LAP_W;

  // Register reset values
  localparam int GRID_RESET = 10;
  localparam int DENS_RESET = 256;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_GRID_SIZE = 1'b0,
    REG_DENSITY   = 1'b1
  } cfg_reg_t;

endpackage

[rtl/lss_sample_if.sv]
// Valid/ready channel that carries one grid sample per word.
// Depends on lss_pkg for the sample type.
interface lss_sample_if;
  import lss_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

[rtl/lss_sum_if.sv]
// Valid/ready channel that carries one saturated energy sum per word.
// Depends on lss_pkg for the sum type.
interface lss_sum_if;
  import lss_pkg::*;

  logic valid;
  logic ready;
  sum_t energy_sum;

  modport source (output valid, output energy_sum, input ready);
  modport sink   (input valid, input energy_sum, output ready);
endinterface

[rtl/laplacian_stencil_sum_unit.sv]
// Five-point Laplacian sum over a streamed square grid, one sample per word.
// Throughput: one sample per cycle unless the input stalls; the line store takes one read
// and one write a cycle. A grid's sum passes stage 2, stage 3 and the output register.
// Input stalls only while a finished sum waits at the output and the next one is due.
// Reset (synchronous, rst high) clears counters, sum and valids and presets the configuration
// registers; line store contents stay undefined until written.
module laplacian_stencil_sum_unit (
  input  logic                 clk,
  input  logic                 rst,
  lss_sample_if.sink           samples,
  lss_sum_if.source            sums,
  input  logic                 wr_en,
  input  lss_pkg::cfg_reg_t    wr_index,
  input  logic [lss_pkg::CFG_W-1:0] wr_data
);
  import lss_pkg::*;

  // Configuration registers
  logic [GS_W-1:0]          grid_size;
  logic signed [DENS_W-1:0] density;

  // Raster position
  logic [COL_W-1:0] col;
  logic [COL_W-1:0] row;
  logic [N_W-1:0]   n_eff;
  logic [N_W-1:0]   n_last;
  logic             row_end;
  logic             grid_end;
  logic             take;
  logic             adv;

  // Line store: {older row, newer row} per column
  logic [2*SAMPLE_W-1:0] line_mem [MAX_GRID];
  logic [2*SAMPLE_W-1:0] rd_word;

  // Stage 2: stencil and product
  logic             s2_valid;
  logic             s2_do;
  logic             s2_last;
  logic [COL_W-1:0] s2_col;
  sample_t          s2_sample;
  sample_t          win_left;
  sample_t          win_mid;
  sample_t          win_up;
  sample_t          win_down;
  sample_t          rd_older;
  sample_t          rd_newer;
  logic signed [LAP_W-1:0]  lap;
  logic signed [PROD_W-1:0] prod;

  // Stage 3: accumulate
  logic                     s3_valid;
  logic                     s3_do;
  logic                     s3_last;
  logic signed [PROD_W-1:0] p3;
  sum_t                     sum;
  logic signed [SUM_W:0]    acc;
  sum_t                     acc_sat;

  // Output register
  logic out_valid;
  sum_t out_sum;

  // Hold the pipeline only when a new sum meets a full output register
  assign adv  = !(s3_valid && s3_last && out_valid && !sums.ready);
  assign take = samples.valid && samples.ready;

  assign samples.ready  = adv && !rst;
  assign sums.valid     = out_valid;
  assign sums.energy_sum = out_sum;

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= GS_W'(GRID_RESET);
      density   <= DENS_W'(DENS_RESET);
    end else if (wr_en) begin
      case (wr_index)
        REG_GRID_SIZE: grid_size <= wr_data[GS_W-1:0];
        REG_DENSITY:   density   <= wr_data[DENS_W-1:0];
        default:       ;
      endcase
    end
  end

  // Clamp the grid size and find row and grid ends
  always_comb begin
    if (grid_size < GS_W'(MIN_GRID)) begin
      n_eff = N_W'(MIN_GRID);
    end else if (32'(grid_size) > MAX_GRID) begin
      n_eff = N_W'(MAX_GRID);
    end else begin
      n_eff = N_W'(grid_size);
    end
    n_last   = n_eff - N_W'(1);
    row_end  = {1'b0, col} >= n_last;
    grid_end = row_end && ({1'b0, row} >= n_last);
  end

  // Advance the raster counters on each taken word
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (take) begin
      if (row_end) begin
        col <= '0;
        row <= grid_end ? '0 : row + COL_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // Read the line store for the taken column
  always_ff @(posedge clk) begin
    if (take) begin
      rd_word <= line_mem[col];
    end
  end

  // Shift the column down the line store as stage 2 retires
  always_ff @(posedge clk) begin
    if (s2_valid && adv) begin
      line_mem[s2_col] <= {rd_newer, s2_sample};
    end
  end

  // Load stage 2
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s2_col    <= col;
      s2_sample <= samples.sample;
      s2_do     <= (row >= COL_W'(2)) && (col >= COL_W'(2));
      s2_last   <= grid_end;
    end
  end

  assign rd_older = rd_word[2*SAMPLE_W-1:SAMPLE_W];
  assign rd_newer = rd_word[SAMPLE_W-1:0];

  // Form the stencil centered one row and one column back
  always_comb begin
    lap = LAP_W'(win_up) + LAP_W'(win_down) + LAP_W'(win_left) + LAP_W'(rd_newer)
        - (LAP_W'(win_mid) <<< 2);
    prod = density * lap;
  end

  // Slide the window and register the product
  always_ff @(posedge clk) begin
    if (s2_valid && adv) begin
      win_left <= win_mid;
      win_mid  <= rd_newer;
      win_up   <= rd_older;
      win_down <= s2_sample;
      p3       <= prod;
      s3_do    <= s2_do;
      s3_last  <= s2_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  // Accumulate with saturation at the sum range
  always_comb begin
    acc = {sum[SUM_W-1], sum} + (s3_do ? (SUM_W+1)'(p3) : '0);
    if (acc[SUM_W] != acc[SUM_W-1]) begin
      acc_sat = acc[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      acc_sat = acc[SUM_W-1:0];
    end
  end

  // Update the sum; drop it into the output word at grid end
  always_ff @(posedge clk) begin
    if (rst) begin
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (s3_valid && adv) begin
        sum <= s3_last ? '0 : acc_sat;
      end
      if (s3_valid && adv && s3_last) begin
        out_valid <= 1'b1;
      end else if (sums.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid && adv && s3_last) begin
      out_sum <= acc_sat;
    end
  end

endmodule

[rtl/lss_checker.sv]
// Port-level checks for the Laplacian stencil sum unit, bound to its top level.
// Depends on the two channel interfaces.
module lss_checker (
  input logic         clk,
  input logic         rst,
  lss_sample_if.sink  samples,
  lss_sum_if.source   sums,
  input logic         wr_en
);

  // A stalled sum word holds its value
  a_sum_hold: assert property (@(posedge clk) disable iff (rst)
    sums.valid && !sums.ready |=> sums.valid && $stable(sums.energy_sum))
    else $error("sum word changed while stalled");

  // No sum word right after reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !sums.valid)
    else $error("sum word valid after reset");

  // Input stalls only behind a waiting sum word
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !samples.ready |-> sums.valid && !sums.ready)
    else $error("input stalled with the output free");

  // No configuration write while a sum word waits
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !sums.valid)
    else $error("configuration write with a sum word pending");

endmodule

bind laplacian_stencil_sum_unit lss_checker u_lss_checker (
  .clk      (clk),
  .rst      (rst),
  .samples  (samples),
  .sums     (sums),
  .wr_en    (wr_en)
);
